### rtl/assert_macros.svh
// Assertion macros shared by the matrix multiply engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define MME_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define MME_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `MME_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies; used by the interfaces and all modules.
package mme_pkg;

  localparam int ENTRY_W   = 24;  // Q8.16 operand entry
  localparam int PROD_W    = 48;  // exact product of two entries
  localparam int RES_W     = 32;  // Q16.16 result
  localparam int IDX_W     = 3;   // row and column fields on the ports
  localparam int KIND_W    = 2;
  localparam int DIM_W     = 4;   // dimension registers
  localparam int CFG_IDX_W = 2;

  localparam logic signed [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Input item kinds; the fourth code is ignored
  typedef enum logic [KIND_W-1:0] {
    KIND_LEFT    = 2'd0,
    KIND_RIGHT   = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_ROWS  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_RIGHT_COLS = 2'd2
  } cfg_reg_e;

  // Tag that travels with each operand pair through the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

### rtl/mme_if.sv
// Valid/ready channel interfaces of the matrix multiply engine.
// Depends on mme_pkg for field widths.
interface mme_in_if import mme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [IDX_W-1:0]          load_row;
  logic [IDX_W-1:0]          load_col;
  logic signed [ENTRY_W-1:0] entry_value;

  modport source (output valid, kind, load_row, load_col, entry_value, input ready);
  modport sink   (input valid, kind, load_row, load_col, entry_value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] product_value;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic                    last;
  logic                    saturated;

  modport source (output valid, product_value, out_row, out_col, last, saturated,
                  input ready);
  modport sink   (input valid, product_value, out_row, out_col, last, saturated,
                  output ready);
endinterface

interface mme_cfg_if import mme_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [DIM_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/mme_store.sv
// Operand store: one write port, one registered read port.
// Depends on mme_pkg for the entry width.
module mme_store import mme_pkg::*; #(
  parameter int Depth = 64,
  localparam int AW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic signed [ENTRY_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic signed [ENTRY_W-1:0] rdata_o
);

  logic signed [ENTRY_W-1:0] mem_q [Depth];
  logic signed [ENTRY_W-1:0] rdata_q;

  // Write on load, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mme_mac.sv
// Shared multiply-accumulate unit with floor shift and 32-bit saturation.
// Depends on mme_pkg for widths, saturation limits and the control tag.
module mme_mac import mme_pkg::*; #(
  parameter int FracBits = 16,
  parameter int AccW     = 51
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_ctrl_t                 ctrl_i,
  input  logic signed [ENTRY_W-1:0] a_i,
  input  logic signed [ENTRY_W-1:0] b_i,
  output logic                      done_o,
  output logic signed [RES_W-1:0]   value_o,
  output logic                      sat_o
);

  mac_ctrl_t                ctrl_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic                     done_q;
  logic signed [AccW-1:0]   shifted;
  logic [AccW-RES_W:0]      hi_bits;
  logic                     ovf;

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Restart the sum on the first term, add otherwise
  always_comb begin
    acc_d = acc_q;
    if (ctrl_q.vld) begin
      if (ctrl_q.first) begin
        acc_d = AccW'(prod_q);
      end else begin
        acc_d = acc_q + AccW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_i;
      acc_q  <= acc_d;
      done_q <= ctrl_q.vld && ctrl_q.last;
    end
  end

  // Drop fraction bits toward minus infinity, then clip to 32 bits
  assign shifted = acc_q >>> FracBits;
  assign hi_bits = shifted[AccW-1:RES_W-1];
  assign ovf     = !((&hi_bits) || !(|hi_bits));

  assign done_o  = done_q;
  assign sat_o   = ovf;
  assign value_o = ovf ? (shifted[AccW-1] ? SAT_MIN : SAT_MAX) : shifted[RES_W-1:0];

endmodule

### rtl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: sequencer, operand stores and MAC.
// Depends on mme_pkg, mme_if, mme_store, mme_mac and assert_macros.svh.
//
// Usage:
//   cfg_i  sets left_rows, inner_size and right_cols (indexes 0, 1, 2); it is
//          always ready. Write it only while no compute item is in flight.
//   in_i   takes load items (kind 0 left, kind 1 right) and compute items
//          (kind 2). The next item may follow a load at once; loads outside
//          MAX_DIM and kind 3 are dropped.
//   out_o  gives the product in row-major order, one transfer per entry,
//          with last set on the final entry.
// A compute item holds in_i.ready low until its last result is transferred.
// Each entry runs the shared multiplier over the inner dimension, one term a
// cycle, then passes the store read, multiply and accumulate registers before
// its result is loaded into the output register.
// A stalled out_o holds the finished entry and pauses the sequencer.
// Reset sets all dimensions to 8 and returns to idle; store contents are
// undefined until loaded.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mme_in_if.sink    in_i,
  mme_out_if.source out_o,
  mme_cfg_if.sink   cfg_i
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int ACC_W = PROD_W + $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  // Last index of a dimension, after clamping to 1..MAX_DIM
  function automatic logic [IW-1:0] dim_lim(input logic [DIM_W-1:0] v);
    logic [IW-1:0] l;
    if (v == '0) begin
      l = '0;
    end else if (32'(v) > MAX_DIM) begin
      l = IW'(MAX_DIM - 1);
    end else begin
      l = IW'(v - 1'b1);
    end
    return l;
  endfunction

  state_e state_q, state_d;
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IW-1:0] r_lim, c_lim, k_lim;
  mac_ctrl_t     iss_ctrl_q, iss_ctrl_d;

  logic                      in_xfer, out_xfer, in_range;
  logic                      left_we, right_we;
  logic [AW-1:0]             waddr, left_raddr, right_raddr;
  logic signed [ENTRY_W-1:0] left_rdata, right_rdata;

  logic                    mac_done, mac_sat;
  logic signed [RES_W-1:0] mac_value;

  logic                    out_valid_q;
  logic signed [RES_W-1:0] value_q;
  logic [IDX_W-1:0]        row_q, col_q;
  logic                    last_q, sat_q;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.reg_index))
        CFG_LEFT_ROWS:  rows_q  <= cfg_i.wdata;
        CFG_INNER_SIZE: inner_q <= cfg_i.wdata;
        CFG_RIGHT_COLS: cols_q  <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  assign r_lim = dim_lim(rows_q);
  assign k_lim = dim_lim(inner_q);
  assign c_lim = dim_lim(cols_q);

  // Load decode
  assign in_range = (32'(in_i.load_row) < MAX_DIM) && (32'(in_i.load_col) < MAX_DIM);
  assign waddr    = AW'(in_i.load_row * MAX_DIM + in_i.load_col);

  always_comb begin
    left_we  = 1'b0;
    right_we = 1'b0;
    unique case (kind_e'(in_i.kind))
      KIND_LEFT:    left_we  = in_xfer && in_range;
      KIND_RIGHT:   right_we = in_xfer && in_range;
      KIND_COMPUTE: ;
      default: ;
    endcase
  end

  assign left_raddr  = AW'(r_q * MAX_DIM + k_q);
  assign right_raddr = AW'(k_q * MAX_DIM + c_q);

  mme_store #(.Depth(DEPTH)) u_left_store (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (waddr),
    .wdata_i (in_i.entry_value),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mme_store #(.Depth(DEPTH)) u_right_store (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (waddr),
    .wdata_i (in_i.entry_value),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  mme_mac #(.FracBits(FRAC_BITS), .AccW(ACC_W)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (iss_ctrl_q),
    .a_i     (left_rdata),
    .b_i     (right_rdata),
    .done_o  (mac_done),
    .value_o (mac_value),
    .sat_o   (mac_sat)
  );

  // Sequencer over rows, columns and inner terms
  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    iss_ctrl_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (kind_e'(in_i.kind) == KIND_COMPUTE)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        iss_ctrl_d.vld   = 1'b1;
        iss_ctrl_d.first = (k_q == '0);
        iss_ctrl_d.last  = (k_q == k_lim);
        if (k_q == k_lim) begin
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          k_d = '0;
          if (c_q == c_lim) begin
            c_d = '0;
            if (r_q == r_lim) begin
              state_d = ST_IDLE;
            end else begin
              r_d     = r_q + IW'(1);
              state_d = ST_ISSUE;
            end
          end else begin
            c_d     = c_q + IW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      iss_ctrl_q <= '0;
    end else begin
      state_q    <= state_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      iss_ctrl_q <= iss_ctrl_d;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Output register: load on MAC completion, drop after transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_WAIT && mac_done) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && mac_done) begin
      value_q <= mac_value;
      sat_q   <= mac_sat;
      row_q   <= IDX_W'(r_q);
      col_q   <= IDX_W'(c_q);
      last_q  <= (r_q == r_lim) && (c_q == c_lim);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = value_q;
  assign out_o.out_row       = row_q;
  assign out_o.out_col       = col_q;
  assign out_o.last          = last_q;
  assign out_o.saturated     = sat_q;

  // Checks
  `include "assert_macros.svh"

  `MME_ASSERT_NEVER(a_in_blocked, clk_i, rst_ni, in_i.ready && out_o.valid, "input open with result")
  `MME_ASSERT_NEVER(a_done_in_wait, clk_i, rst_ni, mac_done && state_q != ST_WAIT, "stray done")
  `MME_ASSERT(a_idle_after_last, clk_i, rst_ni, out_xfer && out_o.last |=> in_i.ready, "not idle")

endmodule

### dv/tb.sv
// Self-checking bench for matrix_multiply_engine: loads operand entries, runs
// fixed-point matrix products and checks every product entry in order.
// Depends on mme_pkg and the channel interfaces in mme_if.
module tb;
  import mme_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int FRAC_BITS     = 16;
  localparam int ITEM_TARGET   = 500;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 24;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [ENTRY_W-1:0] value;
    bit                        drain;
  } gemm_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
    logic                    sat;
  } prod_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mme_in_if  in_if ();
  mme_out_if out_if ();
  mme_cfg_if cfg_if ();

  matrix_multiply_engine #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Predictor state: operand stores and dimension registers
  logic signed [ENTRY_W-1:0] left_mat  [MAX_DIM*MAX_DIM];
  logic signed [ENTRY_W-1:0] right_mat [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]          dim_reg   [3] = '{default: 4'd8};

  // Stimulus-side bookkeeping of which entries hold a value
  bit left_loaded  [MAX_DIM*MAX_DIM];
  bit right_loaded [MAX_DIM*MAX_DIM];

  gemm_item_t  pend_items [$];
  prod_entry_t product_q  [$];

  logic in_fire_q;
  bit   steady;
  logic hold_off;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   issued;
  event long_hold_ev;

  always #6 clk_i = ~clk_i;

  function automatic int eff_dim(logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  // Update the stores or expand a compute item into its product entries
  function automatic void apply_gemm_item(gemm_item_t it);
    int          nr, nk, nc, r, c, k;
    longint      acc;
    longint      q;
    prod_entry_t ent;
    if (it.kind == KIND_LEFT) begin
      left_mat[int'(it.row)*MAX_DIM + int'(it.col)] = it.value;
    end else if (it.kind == KIND_RIGHT) begin
      right_mat[int'(it.row)*MAX_DIM + int'(it.col)] = it.value;
    end else if (it.kind == KIND_COMPUTE) begin
      nr = eff_dim(dim_reg[CFG_LEFT_ROWS]);
      nk = eff_dim(dim_reg[CFG_INNER_SIZE]);
      nc = eff_dim(dim_reg[CFG_RIGHT_COLS]);
      for (r = 0; r < nr; r++) begin
        for (c = 0; c < nc; c++) begin
          acc = 0;
          for (k = 0; k < nk; k++) begin
            acc += longint'(left_mat[r*MAX_DIM + k]) * longint'(right_mat[k*MAX_DIM + c]);
          end
          // floor shift, then clip to 32 bits
          q = acc >>> FRAC_BITS;
          ent.sat = 1'b0;
          if (q > longint'(SAT_MAX)) begin
            q = longint'(SAT_MAX);
            ent.sat = 1'b1;
          end else if (q < longint'(SAT_MIN)) begin
            q = longint'(SAT_MIN);
            ent.sat = 1'b1;
          end
          ent.value = q[RES_W-1:0];
          ent.row   = IDX_W'(r);
          ent.col   = IDX_W'(c);
          ent.last  = (r == nr - 1) && (c == nc - 1);
          product_q.push_back(ent);
        end
      end
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // Record input transfers and run them through the predictor
  always @(posedge clk_i or negedge rst_ni) begin : in_accept
    gemm_item_t it;
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        it.kind  = in_if.kind;
        it.row   = in_if.load_row;
        it.col   = in_if.load_col;
        it.value = in_if.entry_value;
        it.drain = 1'b0;
        apply_gemm_item(it);
      end
    end
  end

  // Offer pending items; idle at random unless steady, hold drain items until all entries are back
  always @(negedge clk_i or negedge rst_ni) begin : feed_items
    gemm_item_t nxt;
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.kind        <= '0;
      in_if.load_row    <= '0;
      in_if.load_col    <= '0;
      in_if.entry_value <= '0;
    end else if (!in_if.valid || in_fire_q) begin
      if (pend_items.size() != 0 && (steady || $urandom_range(99) >= 33) &&
          !(pend_items[0].drain && product_q.size() != 0)) begin
        nxt = pend_items.pop_front();
        in_if.valid       <= 1'b1;
        in_if.kind        <= nxt.kind;
        in_if.load_row    <= nxt.row;
        in_if.load_col    <= nxt.col;
        in_if.entry_value <= nxt.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Drive result ready: random stalls, none while steady, low during the long hold
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && (steady || $urandom_range(99) >= 33);
    end
  end

  // Hold the result side off for a long stretch on request
  initial begin
    hold_off = 1'b0;
    forever begin
      @(long_hold_ev);
      @(posedge clk_i);
      hold_off = 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
      hold_off = 1'b0;
    end
  end

  // Compare each result transfer with the oldest predicted entry
  always @(posedge clk_i) begin : out_check
    prod_entry_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (product_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected entry row %0d col %0d value %0d",
                                out_if.out_row, out_if.out_col, out_if.product_value));
      end else begin
        want = product_q.pop_front();
        if (out_if.product_value !== want.value)
          flag_mismatch($sformatf("value at (%0d,%0d): got %0d want %0d", want.row,
                                  want.col, out_if.product_value, want.value));
        if (out_if.out_row !== want.row)
          flag_mismatch($sformatf("row: got %0d want %0d", out_if.out_row, want.row));
        if (out_if.out_col !== want.col)
          flag_mismatch($sformatf("col: got %0d want %0d", out_if.out_col, want.col));
        if (out_if.last !== want.last)
          flag_mismatch($sformatf("last at (%0d,%0d): got %b want %b", want.row, want.col,
                                  out_if.last, want.last));
        if (out_if.saturated !== want.sat)
          flag_mismatch($sformatf("saturated at (%0d,%0d): got %b want %b", want.row,
                                  want.col, out_if.saturated, want.sat));
      end
    end
  end

  function automatic logic signed [ENTRY_W-1:0] pick_entry();
    case ($urandom_range(7))
      0:       return ENTRY_MIN;
      1:       return ENTRY_MAX;
      2:       return '0;
      3:       return '1;
      4:       return 1;
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [KIND_W-1:0] kind, int row, int col,
                           logic signed [ENTRY_W-1:0] value, bit drain);
    gemm_item_t it;
    it.kind  = kind;
    it.row   = IDX_W'(row);
    it.col   = IDX_W'(col);
    it.value = value;
    it.drain = drain;
    pend_items.push_back(it);
    if (kind == KIND_LEFT) left_loaded[row*MAX_DIM + col] = 1'b1;
    if (kind == KIND_RIGHT) right_loaded[row*MAX_DIM + col] = 1'b1;
    if (kind != KIND_UNUSED) issued++;
  endtask

  // Load every entry the next product reads that has never been written
  task automatic fill_operands();
    int nr, nk, nc, a, b;
    nr = eff_dim(dim_reg[CFG_LEFT_ROWS]);
    nk = eff_dim(dim_reg[CFG_INNER_SIZE]);
    nc = eff_dim(dim_reg[CFG_RIGHT_COLS]);
    for (a = 0; a < nr; a++)
      for (b = 0; b < nk; b++)
        if (!left_loaded[a*MAX_DIM + b]) push_item(KIND_LEFT, a, b, pick_entry(), 1'b0);
    for (a = 0; a < nk; a++)
      for (b = 0; b < nc; b++)
        if (!right_loaded[a*MAX_DIM + b]) push_item(KIND_RIGHT, a, b, pick_entry(), 1'b0);
  endtask

  task automatic write_dim(cfg_reg_e idx, logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    dim_reg[idx] = val;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] inner,
                          logic [DIM_W-1:0] cols);
    write_dim(CFG_LEFT_ROWS, rows);
    write_dim(CFG_INNER_SIZE, inner);
    write_dim(CFG_RIGHT_COLS, cols);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all items to transfer and all entries to return, then let the block settle
  task automatic wait_drained();
    while (pend_items.size() != 0 || in_if.valid) @(posedge clk_i);
    while (product_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int                  k, n, n_comp, phase_no, pick;
    logic [DIM_W-1:0]    d_rows, d_inner, d_cols;
    logic [KIND_W-1:0]   lk;

    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = '0;
    cfg_if.wdata      = '0;
    steady            = 1'b0;
    issued            = 0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero dimensions act as one: floor of a tiny negative product, ignored kind
    set_dims(4'd0, 4'd0, 4'd0);
    push_item(KIND_LEFT, 0, 0, '1, 1'b0);
    push_item(KIND_RIGHT, 0, 0, 1, 1'b0);
    push_item(KIND_UNUSED, 7, 7, ENTRY_MAX, 1'b0);
    push_item(KIND_COMPUTE, 0, 0, '0, 1'b0);
    push_item(KIND_LEFT, 0, 0, ENTRY_MIN, 1'b0);
    push_item(KIND_RIGHT, 0, 0, ENTRY_MIN, 1'b0);
    push_item(KIND_COMPUTE, 7, 7, '1, 1'b0);
    wait_drained();

    // Both saturation directions and mixed extremes on a 2x3 by 3x2 product
    set_dims(4'd2, 4'd3, 4'd2);
    for (k = 0; k < 3; k++) begin
      push_item(KIND_LEFT, 0, k, ENTRY_MIN, 1'b0);
      push_item(KIND_RIGHT, k, 0, ENTRY_MIN, 1'b0);
      push_item(KIND_RIGHT, k, 1, ENTRY_MAX, 1'b0);
    end
    push_item(KIND_LEFT, 1, 0, ENTRY_MAX, 1'b0);
    push_item(KIND_LEFT, 1, 1, '0, 1'b0);
    push_item(KIND_LEFT, 1, 2, '1, 1'b0);
    push_item(KIND_COMPUTE, 0, 0, '0, 1'b0);
    wait_drained();

    // Random phases: new shape, well-formed load and compute runs with noise
    phase_no = 0;
    while (issued < ITEM_TARGET) begin
      phase_no++;
      if (phase_no == 1) begin
        d_rows  = 4'd15;
        d_inner = 4'd0;
        d_cols  = 4'd8;
      end else if (phase_no % 5 == 0) begin
        d_rows  = DIM_W'(8 + $urandom_range(7));
        d_inner = DIM_W'(8 + $urandom_range(7));
        d_cols  = DIM_W'(8 + $urandom_range(7));
      end else begin
        d_rows  = ($urandom_range(9) == 0) ? 4'd0 : DIM_W'($urandom_range(1, 4));
        d_inner = ($urandom_range(9) == 0) ? 4'd0 : DIM_W'($urandom_range(1, 4));
        d_cols  = ($urandom_range(9) == 0) ? 4'd0 : DIM_W'($urandom_range(1, 4));
      end
      set_dims(d_rows, d_inner, d_cols);
      steady = (phase_no == 2);
      n_comp = (phase_no == 3) ? 3 : $urandom_range(1, 3);

      for (n = 0; n < n_comp; n++) begin
        // stray loads anywhere in the stores
        repeat ($urandom_range(0, 6)) begin
          lk = $urandom_range(1) ? KIND_LEFT : KIND_RIGHT;
          push_item(lk, $urandom_range(7), $urandom_range(7), pick_entry(), 1'b0);
        end
        if ($urandom_range(3) == 0)
          push_item(KIND_UNUSED, $urandom_range(7), $urandom_range(7),
                    ENTRY_W'($urandom), 1'b0);
        fill_operands();
        // rewrite some entries inside the active shape
        repeat ($urandom_range(0, 4)) begin
          pick = $urandom_range(1);
          if (pick == 0)
            push_item(KIND_LEFT, $urandom_range(eff_dim(d_rows) - 1),
                      $urandom_range(eff_dim(d_inner) - 1), pick_entry(), 1'b0);
          else
            push_item(KIND_RIGHT, $urandom_range(eff_dim(d_inner) - 1),
                      $urandom_range(eff_dim(d_cols) - 1), pick_entry(), 1'b0);
        end
        push_item(KIND_COMPUTE, $urandom_range(7), $urandom_range(7),
                  ENTRY_W'($urandom), $urandom_range(7) == 0);
      end

      if (phase_no == 3) -> long_hold_ev;
      wait_drained();
      steady = 1'b0;
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### matrix_multiply_engine.f
+incdir+rtl
rtl/mme_pkg.sv
rtl/mme_if.sv
rtl/mme_store.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine.sv
dv/tb.sv
